### sv/pal_pkg.sv
// shared package for the positional array list
// field widths, action and status codes, controller/datapath command and status types
// no dependencies
package pal_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 16;

  // fixed field widths
  localparam int ACT_W = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_OUT_W = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic            ld;          // latch an accepted request
    logic            k_init;      // preset the index for the action
    logic            k_inc;
    logic            k_dec;
    logic            rd;          // issue a memory read
    logic            wr_mv;       // write back the entry just read
    logic            wr_val;      // write the request value
    logic            cnt_inc;
    logic            cnt_dec;
    logic            res_load;    // capture a result
    logic [ST_W-1:0] res_status;
    logic            res_rd_sel;  // result carries the entry read
    logic            res_fnd_sel; // result carries index plus one
    logic            push;        // move result into the output register
  } pal_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             pos_bad;   // position out of range for the action
    logic             full;
    logic             cnt_zero;
    logic             k_at_pos;  // index equals position minus one
    logic             k_at_cnt;  // index equals count
    logic             k_last;    // index plus one equals count
    logic             match;     // entry read equals request value
    logic             out_free;  // output register can take a result
  } pal_sts_t;

endpackage

### sv/pal_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/pal_ctrl.sv
// controller state machine for the positional array list
// depends on pal_pkg; drives pal_dpath through pal_cmd_t, reads pal_sts_t
module pal_ctrl
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  output logic     in_rdy,
  input  pal_sts_t sts,
  output pal_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_GRD  = 4'd2;
  localparam logic [3:0] S_GETW = 4'd3;
  localparam logic [3:0] S_LRD  = 4'd4;
  localparam logic [3:0] S_LCMP = 4'd5;
  localparam logic [3:0] S_IMOV = 4'd6;
  localparam logic [3:0] S_IWR  = 4'd7;
  localparam logic [3:0] S_DMOV = 4'd8;
  localparam logic [3:0] S_DWR  = 4'd9;
  localparam logic [3:0] S_PUSH = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_rdy = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.ld    = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.k_init = 1'b1;
        unique case (sts.act)
          ACT_GET: begin
            if (sts.pos_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BAD_POS;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_GRD;
            end
          end
          ACT_LOCATE: begin
            if (sts.cnt_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_LRD;
            end
          end
          ACT_INSERT: begin
            if (sts.pos_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BAD_POS;
              state_nxt      = S_PUSH;
            end else if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_IMOV;
            end
          end
          default: begin
            if (sts.pos_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BAD_POS;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_DMOV;
            end
          end
        endcase
      end
      // get: one read round trip
      S_GRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_GETW;
      end
      S_GETW: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_rd_sel = 1'b1;
        state_nxt      = S_PUSH;
      end
      // locate: read then compare, entry by entry
      S_LRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LCMP;
      end
      S_LCMP: begin
        if (sts.match) begin
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_OK;
          cmd.res_fnd_sel = 1'b1;
          state_nxt       = S_PUSH;
        end else if (sts.k_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_PUSH;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_LRD;
        end
      end
      // insert: shift entries up from the top, then drop the value in
      S_IMOV: begin
        if (sts.k_at_pos) begin
          cmd.wr_val     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_PUSH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_IWR;
        end
      end
      S_IWR: begin
        cmd.wr_mv = 1'b1;
        cmd.k_dec = 1'b1;
        state_nxt = S_IMOV;
      end
      // delete: shift entries down from the position
      S_DMOV: begin
        if (sts.k_at_cnt) begin
          cmd.cnt_dec    = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_PUSH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        cmd.wr_mv = 1'b1;
        cmd.k_inc = 1'b1;
        state_nxt = S_DMOV;
      end
      // wait for the output register
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/pal_dpath.sv
// datapath for the positional array list: request latch, count, index, entry ram,
// result and output registers; depends on pal_pkg and pal_ram
module pal_dpath
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  pal_cmd_t                cmd,
  output pal_sts_t                sts,
  input  logic                    out_rdy,
  output logic                    out_vld,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [POS_W-1:0]        out_found_position,
  output logic [CNT_OUT_W-1:0]    out_count
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EXT_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int OEXT_W = ((CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W);

  logic [ACT_W-1:0]        act_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [ST_W-1:0]         res_st_r;
  logic [VAL_W-1:0]        res_rd_r;
  logic [POS_W-1:0]        res_fnd_r;
  logic                    out_vld_r, out_vld_nxt;
  logic [ST_W-1:0]         out_st_r;
  logic [VAL_W-1:0]        out_rd_r;
  logic [POS_W-1:0]        out_fnd_r;
  logic [CNT_OUT_W-1:0]    out_cnt_r;

  logic [EXT_W-1:0]  pos_x, cnt_x, k_x, pos_m1_x, k_p1_x, lim_x;
  logic [CNT_W-1:0]  k_m1;
  logic [OEXT_W-1:0] cnt_o;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [VAL_W-1:0]  wdata, rdata;
  logic              we;

  // widened copies for compares
  assign pos_x    = EXT_W'(pos_r);
  assign cnt_x    = EXT_W'(cnt_r);
  assign k_x      = EXT_W'(k_r);
  assign pos_m1_x = pos_x - EXT_W'(1);
  assign k_p1_x   = k_x + EXT_W'(1);
  assign k_m1     = k_r - CNT_W'(1);
  assign cnt_o    = OEXT_W'(cnt_r);

  // highest legal position: count for get and delete, count plus one for insert
  assign lim_x = (act_r == ACT_INSERT) ? (cnt_x + EXT_W'(1)) : cnt_x;

  // status to controller
  always_comb begin
    sts.act      = act_r;
    sts.pos_bad  = (pos_r == '0) || (pos_x > lim_x);
    sts.full     = (cnt_x == EXT_W'(CAPACITY));
    sts.cnt_zero = (cnt_r == '0);
    sts.k_at_pos = (k_x == pos_m1_x);
    sts.k_at_cnt = (k_r == cnt_r);
    sts.k_last   = (k_p1_x == cnt_x);
    sts.match    = (rdata == val_r);
    sts.out_free = !out_vld_r || out_rdy;
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  // index preset and stepping
  always_comb begin
    k_nxt = k_r;
    if (cmd.k_init) begin
      unique case (act_r)
        ACT_GET:    k_nxt = pos_m1_x[CNT_W-1:0];
        ACT_LOCATE: k_nxt = '0;
        ACT_INSERT: k_nxt = cnt_r;
        default:    k_nxt = pos_x[CNT_W-1:0];
      endcase
    end else if (cmd.k_inc) begin
      k_nxt = k_r + CNT_W'(1);
    end else if (cmd.k_dec) begin
      k_nxt = k_m1;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  // entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ram addressing: insert reads below the index, delete writes below it
  assign raddr = (act_r == ACT_INSERT) ? k_m1[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign waddr = (act_r == ACT_DELETE) ? k_m1[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign wdata = cmd.wr_val ? val_r : rdata;
  assign we    = cmd.wr_mv || cmd.wr_val;

  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st_r  <= cmd.res_status;
      res_rd_r  <= cmd.res_rd_sel ? rdata : '0;
      res_fnd_r <= cmd.res_fnd_sel ? k_p1_x[POS_W-1:0] : '0;
    end
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.push) begin
      out_vld_nxt = 1'b1;
    end else if (out_rdy) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_st_r  <= res_st_r;
      out_rd_r  <= res_rd_r;
      out_fnd_r <= res_fnd_r;
      out_cnt_r <= cnt_o[CNT_OUT_W-1:0];
    end
  end

  assign out_vld            = out_vld_r;
  assign out_status         = out_st_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_fnd_r;
  assign out_count          = out_cnt_r;

endmodule

### sv/positional_array_list.sv
// top level of the positional array list: stream ports, controller and datapath
// depends on pal_pkg, pal_ctrl, pal_dpath (and pal_ram below it)
//
//  channel | direction | tdata fields, lowest bit up
//  in_     | slave     | action[1:0] position[6:2] value[38:7], zero fill to 40
//  out_    | master    | status[1:0] read_value[33:2] found_position[38:34]
//          |           | count[43:39], zero fill to 48
//
// one request at a time; the entries sit in a ram with registered read, so every
// entry moved or compared takes a read state and then a write or compare state;
// every request goes from accept through decode to the push state before the next
// one is taken, and a rejected request goes from decode straight to push.
// rst_n (synchronous) clears the count and the output valid; the ram holds no reset.
// the output register holds a result under back-pressure; the controller waits for
// it before it takes the next request.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action, position, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, read_value, found_position, count
);

  pal_cmd_t                cmd;
  pal_sts_t                sts;
  logic                    in_rdy;
  logic [ST_W-1:0]         o_status;
  logic signed [VAL_W-1:0] o_read_value;
  logic [POS_W-1:0]        o_found_position;
  logic [CNT_OUT_W-1:0]    o_count;

  assign in_tready = in_rdy;

  pal_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_rdy),
    .in_rdy  (in_rdy),
    .sts     (sts),
    .cmd     (cmd)
  );

  pal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_tdata[1:0]),
    .in_position        (in_tdata[6:2]),
    .in_value           (in_tdata[38:7]),
    .cmd                (cmd),
    .sts                (sts),
    .out_rdy            (out_tready),
    .out_vld            (out_tvalid),
    .out_status         (o_status),
    .out_read_value     (o_read_value),
    .out_found_position (o_found_position),
    .out_count          (o_count)
  );

  // pack the result
  assign out_tdata = {4'b0000, o_count, o_found_position, o_read_value, o_status};

endmodule

### sim/tb.sv
// self-checking testbench for positional_array_list: directed then random list actions
// under varied idling and a long output hold-off, checked against a shadow list model
// depends on pal_pkg and positional_array_list
module tb;
  import pal_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 120;
  localparam int PHASE_ITEMS = 350;

  // one expected response, fields as they leave the block (last member lowest)
  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [POS_W-1:0]     found_position;
    logic [VAL_W-1:0]     read_value;
    logic [ST_W-1:0]      status;
  } pal_result_t;

  // shadow copy of the list and the responses it still owes
  class list_shadow;
    logic [VAL_W-1:0] list_mem[LIST_CAP];
    int               fill;
    pal_result_t      owed_results[$];
    int               errors;
    int               n_checked;
    int               status_hist[4];

    function new();
      fill   = 0;
      errors = 0;
      n_checked = 0;
      foreach (status_hist[i]) status_hist[i] = 0;
    endfunction

    // apply one action to the shadow list and work out its response
    function pal_result_t apply_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                       logic [VAL_W-1:0] val);
      pal_result_t r;
      int          k;
      r = '0;
      case (act)
        ACT_GET: begin
          if (pos == 0 || pos > fill) r.status = ST_BAD_POS;
          else r.read_value = list_mem[int'(pos) - 1];
        end
        ACT_LOCATE: begin
          r.status = ST_NOT_FOUND;
          for (k = 0; k < fill; k++) begin
            if (r.status == ST_NOT_FOUND && list_mem[k] == val) begin
              r.status = ST_OK;
              r.found_position = POS_W'(k + 1);
            end
          end
        end
        ACT_INSERT: begin
          if (pos == 0 || pos > fill + 1) r.status = ST_BAD_POS;
          else if (fill >= LIST_CAP) r.status = ST_FULL;
          else begin
            for (k = fill; k > int'(pos) - 1; k--) list_mem[k] = list_mem[k - 1];
            list_mem[int'(pos) - 1] = val;
            fill++;
          end
        end
        default: begin
          if (pos == 0 || pos > fill) r.status = ST_BAD_POS;
          else begin
            for (k = pos; k < fill; k++) list_mem[k - 1] = list_mem[k];
            fill--;
          end
        end
      endcase
      r.count = CNT_OUT_W'(fill);
      return r;
    endfunction

    task note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      owed_results.push_back(apply_action(act, pos, val));
    endtask

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // compare one response against the oldest one owed
    task check_result(logic [47:0] data);
      pal_result_t got;
      pal_result_t want;
      got = data[43:0];
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected response %h", data));
      end else begin
        want = owed_results.pop_front();
        n_checked++;
        status_hist[want.status]++;
        if (got.status != want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.read_value != want.read_value)
          report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
        if (got.found_position != want.found_position)
          report($sformatf("found_position %0d, expected %0d",
                           got.found_position, want.found_position));
        if (got.count != want.count)
          report($sformatf("count %0d, expected %0d", got.count, want.count));
        if (data[47:44] != '0)
          report($sformatf("fill bits %h not zero", data[47:44]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  list_shadow shadow;
  int         idle_pct = 0;
  int         stall_pct = 0;
  bit         rx_hold = 1'b0;
  int         cycle_count = 0;
  int         act_hist[4] = '{0, 0, 0, 0};

  positional_array_list u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run limit of %0d cycles reached", CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // receiver ready, random stalls or a long hold-off
  always @(negedge clk) begin
    out_tready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= stall_pct);
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata);
  end

  // offer one request, with a random gap first, and note it once taken
  task automatic send_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos, act};
    do @(posedge clk); while (!in_tready);
    shadow.note_request(act, pos, val);
    act_hist[act]++;
  endtask

  // random request, mostly well-formed against the current list
  task automatic make_request(input bit grow, output logic [ACT_W-1:0] act,
                              output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
    int n;
    int r;
    int v;
    n = shadow.fill;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 10) begin
      // noise
      act = ACT_W'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 17));
      val = $urandom;
    end else begin
      if (grow)
        act = (r < 55) ? ACT_INSERT : (r < 70) ? ACT_GET : (r < 85) ? ACT_LOCATE : ACT_DELETE;
      else
        act = (r < 55) ? ACT_DELETE : (r < 70) ? ACT_GET : (r < 85) ? ACT_LOCATE : ACT_INSERT;
      if ($urandom_range(0, 99) < 85) begin
        if (act == ACT_INSERT) pos = POS_W'($urandom_range(1, n + 1));
        else if (n > 0) pos = POS_W'($urandom_range(1, n));
        else pos = POS_W'($urandom_range(0, 17));
      end else begin
        pos = POS_W'($urandom_range(0, 17));
      end
      // small values make duplicates, so first-match gets exercised
      v = $urandom_range(0, 9);
      if (v < 3) val = $urandom_range(0, 3);
      else if (v == 3) begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'hffff_ffff;
          default: val = 32'h0;
        endcase
      end else val = $urandom;
      if (act == ACT_LOCATE && n > 0 && $urandom_range(0, 99) < 60)
        val = shadow.list_mem[$urandom_range(0, n - 1)];
    end
  endtask

  task automatic run_random(int items);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               grow;
    grow = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) grow = 1'($urandom_range(0, 1));
      make_request(grow, act, pos, val);
      send_request(act, pos, val);
    end
  endtask

  // main sequence
  initial begin
    shadow = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, ends, middle, duplicates, bad position and not found
    send_request(ACT_GET,    5'd0,  32'h0);
    send_request(ACT_GET,    5'd1,  32'h0);
    send_request(ACT_DELETE, 5'd1,  32'h0);
    send_request(ACT_LOCATE, 5'd0,  32'h0);
    send_request(ACT_INSERT, 5'd0,  32'h1);
    send_request(ACT_INSERT, 5'd2,  32'h1);
    send_request(ACT_INSERT, 5'd1,  32'h8000_0000);
    send_request(ACT_INSERT, 5'd2,  32'h7fff_ffff);
    send_request(ACT_INSERT, 5'd1,  32'h0);
    send_request(ACT_INSERT, 5'd4,  32'hffff_ffff);
    send_request(ACT_INSERT, 5'd3,  32'hffff_ffff);
    send_request(ACT_LOCATE, 5'd0,  32'hffff_ffff);
    send_request(ACT_LOCATE, 5'd17, 32'h8000_0000);
    send_request(ACT_GET,    5'd5,  32'h5555_5555);
    send_request(ACT_GET,    5'd6,  32'h0);
    send_request(ACT_GET,    5'd17, 32'h0);
    send_request(ACT_INSERT, 5'd17, 32'haaaa_aaaa);
    send_request(ACT_DELETE, 5'd6,  32'h0);
    send_request(ACT_DELETE, 5'd5,  32'h0);
    send_request(ACT_DELETE, 5'd1,  32'hffff_ffff);
    send_request(ACT_LOCATE, 5'd31 & 5'd16, 32'h1234_5678);
    send_request(ACT_DELETE, 5'd0,  32'h0);
    send_request(ACT_INSERT, 5'd5,  32'h0);

    // random phases: no idling, idle sender, stalling receiver, both
    idle_pct = 0;  stall_pct = 0;  run_random(PHASE_ITEMS);

    // long output hold-off while requests keep coming
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    run_random(30);

    idle_pct = 79; stall_pct = 0;  run_random(PHASE_ITEMS);
    idle_pct = 0;  stall_pct = 79; run_random(PHASE_ITEMS);
    idle_pct = 22; stall_pct = 22; run_random(PHASE_ITEMS);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.owed_results.size() != 0)
      shadow.report($sformatf("%0d responses never arrived", shadow.owed_results.size()));

    $display("covered %0d requests: %0d get, %0d locate, %0d insert, %0d delete",
             shadow.n_checked, act_hist[ACT_GET], act_hist[ACT_LOCATE],
             act_hist[ACT_INSERT], act_hist[ACT_DELETE]);
    $display("responses: %0d ok, %0d bad position, %0d list full, %0d not found",
             shadow.status_hist[ST_OK], shadow.status_hist[ST_BAD_POS],
             shadow.status_hist[ST_FULL], shadow.status_hist[ST_NOT_FOUND]);
    if (shadow.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
